@@ rtl/naf_pkg.sv @@
// Package for the nondeterministic address filter: sizes, event codes, state types.
`timescale 1ns / 1ps
package naf_pkg;
  localparam int unsigned SPAN_DEF = 4096;
  localparam int unsigned ADDR_W = 64;
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned TOTAL_W = 13;
  localparam int unsigned PADDR_W = 4;

  localparam logic [FUNC_W-1:0] F_START_DET = 3'd0;
  localparam logic [FUNC_W-1:0] F_START_RUN = 3'd1;
  localparam logic [FUNC_W-1:0] F_RECORD    = 3'd2;
  localparam logic [FUNC_W-1:0] F_END_RUN   = 3'd3;
  localparam logic [FUNC_W-1:0] F_END_DET   = 3'd4;
  localparam logic [FUNC_W-1:0] F_QUERY     = 3'd5;

  localparam logic [PADDR_W-1:0] REG_RANGE_BASE = 4'h0;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_SWEEP,
    S_QRD
  } state_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;
endpackage

@@ rtl/naf_if.sv @@
// Handshake channel interfaces for events and results.
`timescale 1ns / 1ps
interface naf_req_if;
  logic                            valid;
  logic                            ready;
  logic [naf_pkg::FUNC_W-1:0]      func;
  logic [naf_pkg::ADDR_W-1:0]      addr;
  modport source (output valid, func, addr, input ready);
  modport sink (input valid, func, addr, output ready);
endinterface

interface naf_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            nondeterministic;
  logic [naf_pkg::TOTAL_W-1:0]     new_count;
  modport source (output valid, nondeterministic, new_count, input ready);
  modport sink (input valid, nondeterministic, new_count, output ready);
endinterface

@@ rtl/nondeterministic_address_filter_top.sv @@
// Top level of the nondeterministic address filter.
// Channels: req carries one event per beat (func, addr); rsp returns one
// beat per event (nondeterministic, new_count). Both use valid/ready and a
// beat moves when valid and ready are high at a rising edge of clk.
// range_base is written over the APB port at byte address 0 (64 bits).
// Record and unused codes go from the queue straight to the result
// register; a query first passes the S_QRD state, for the memory read.
// Start/end events sweep all SPAN entries and answer when the sweep ends.
// One event is worked on at a time in the back end; the two-entry queue
// lets the front take up to two more. No new event is taken until the
// single result register has been drained.
// Reset (rst, synchronous) clears all control state and then starts a
// clearing pass over all three memories; req.ready stays low until it
// ends. A stalled rsp holds its beat and stops the back end; the front
// keeps filling the queue until it is full.
`timescale 1ns / 1ps
module nondeterministic_address_filter_top #(
  parameter int unsigned SPAN = naf_pkg::SPAN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  naf_req_if.sink                       req,
  naf_rsp_if.source                     rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [naf_pkg::PADDR_W-1:0]   paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready
);
  localparam int unsigned AW = $clog2(SPAN);
  localparam int unsigned QW = naf_pkg::FUNC_W + 1 + AW;

  logic [naf_pkg::ADDR_W-1:0] range_base;
  logic q_not_full, q_not_empty, push, pop, ov;
  logic [AW-1:0] off;
  logic [QW-1:0] q_din, q_dout;
  naf_pkg::back_status_t status;

  assign pready = 1'b1;
  assign prdata = (paddr == naf_pkg::REG_RANGE_BASE) ? range_base : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_base <= '0;
    end else if (psel && penable && pwrite && (paddr == naf_pkg::REG_RANGE_BASE)) begin
      range_base <= pwdata;
    end
  end

  naf_front #(.SPAN(SPAN)) u_front (
    .base(range_base),
    .enable(!status.init_busy),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .addr(req.addr),
    .q_ready(q_not_full),
    .push(push),
    .ov(ov),
    .off(off)
  );

  assign q_din = {req.func, ov, off};

  naf_queue #(.W(QW)) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .din(q_din),
    .not_full(q_not_full),
    .pop(pop),
    .not_empty(q_not_empty),
    .dout(q_dout)
  );

  naf_back #(.SPAN(SPAN)) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_not_empty),
    .q_pop(pop),
    .q_func(q_dout[QW-1 -: naf_pkg::FUNC_W]),
    .q_ov(q_dout[AW]),
    .q_off(q_dout[AW-1:0]),
    .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready),
    .rsp_nd(rsp.nondeterministic),
    .rsp_count(rsp.new_count),
    .status(status)
  );
endmodule

@@ rtl/naf_front.sv @@
// Front end: accept events, check the monitored range and form the offset.
`timescale 1ns / 1ps
module naf_front #(
  parameter int unsigned SPAN = naf_pkg::SPAN_DEF
) (
  input  logic [naf_pkg::ADDR_W-1:0]  base,
  input  logic                        enable,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [naf_pkg::ADDR_W-1:0]  addr,
  input  logic                        q_ready,
  output logic                        push,
  output logic                        ov,
  output logic [$clog2(SPAN)-1:0]     off
);
  localparam int unsigned AW = $clog2(SPAN);
  localparam logic [naf_pkg::ADDR_W-1:0] SPAN_V = naf_pkg::ADDR_W'(SPAN);

  logic [naf_pkg::ADDR_W-1:0] diff;

  assign diff = addr - base;
  assign ov = (addr >= base) && (diff < SPAN_V);
  assign off = diff[AW-1:0];
  assign req_ready = q_ready && enable;
  assign push = req_valid && req_ready;
endmodule

@@ rtl/naf_queue.sv @@
// Two-entry queue between front and back.
`timescale 1ns / 1ps
module naf_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         not_full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] dout
);
  logic [W-1:0] mem [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;

  assign not_full = (count != 2'd2);
  assign not_empty = (count != 2'd0);
  assign dout = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= din;
  end
endmodule

@@ rtl/naf_back.sv @@
// Back end: hit map, counters and mark map with sweeps, result register.
`timescale 1ns / 1ps
module naf_back #(
  parameter int unsigned SPAN = naf_pkg::SPAN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  logic [naf_pkg::FUNC_W-1:0]    q_func,
  input  logic                          q_ov,
  input  logic [$clog2(SPAN)-1:0]       q_off,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic                          rsp_nd,
  output logic [naf_pkg::TOTAL_W-1:0]   rsp_count,
  output naf_pkg::back_status_t         status
);
  localparam int unsigned AW = $clog2(SPAN);
  localparam int unsigned CW = $clog2(SPAN + 1);
  localparam logic [CW-1:0] SPAN_C = CW'(SPAN);

  naf_pkg::state_t state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic rd_valid, rd_valid_next;
  logic [AW-1:0] rd_idx, rd_idx_next;
  logic [naf_pkg::FUNC_W-1:0] op, op_next;
  logic ov_r, ov_r_next;
  logic [naf_pkg::CNT_W-1:0] run_count, run_count_next;
  logic [naf_pkg::TOTAL_W-1:0] marked_total, marked_total_next;
  logic load_rsp;
  logic nd_next;

  logic hit_mem [SPAN];
  logic [naf_pkg::CNT_W-1:0] cnt_mem [SPAN];
  logic mark_mem [SPAN];
  logic hit_q;
  logic [naf_pkg::CNT_W-1:0] cnt_q;
  logic mark_q;
  logic [AW-1:0] raddr;

  logic hit_we, hit_wd;
  logic [AW-1:0] hit_wa;
  logic cnt_we;
  logic [naf_pkg::CNT_W-1:0] cnt_wd;
  logic mark_we, mark_wd;
  logic init_w;
  logic issue;

  assign init_w = (state == naf_pkg::S_INIT);
  assign raddr = (state == naf_pkg::S_IDLE) ? q_off : cnt[AW-1:0];
  assign issue = (cnt < SPAN_C);
  assign status.init_busy = init_w;

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    rd_valid_next = 1'b0;
    rd_idx_next = rd_idx;
    op_next = op;
    ov_r_next = ov_r;
    run_count_next = run_count;
    q_pop = 1'b0;
    load_rsp = 1'b0;
    nd_next = 1'b0;
    case (state)
      naf_pkg::S_INIT, naf_pkg::S_SWEEP: begin
        rd_valid_next = issue;
        rd_idx_next = cnt[AW-1:0];
        cnt_next = cnt + CW'(issue);
        if (!issue && !rd_valid) begin
          load_rsp = !init_w;
          state_next = naf_pkg::S_IDLE;
        end
      end
      naf_pkg::S_IDLE: begin
        if (q_valid && !rsp_valid) begin
          q_pop = 1'b1;
          op_next = q_func;
          ov_r_next = q_ov;
          case (q_func)
            naf_pkg::F_START_DET, naf_pkg::F_START_RUN,
            naf_pkg::F_END_RUN, naf_pkg::F_END_DET: begin
              cnt_next = '0;
              state_next = naf_pkg::S_SWEEP;
              if (q_func == naf_pkg::F_START_DET) run_count_next = '0;
              if (q_func == naf_pkg::F_END_RUN) run_count_next = run_count + 1'b1;
            end
            naf_pkg::F_QUERY: begin
              state_next = naf_pkg::S_QRD;
            end
            default: begin
              load_rsp = 1'b1;
            end
          endcase
        end
      end
      naf_pkg::S_QRD: begin
        load_rsp = 1'b1;
        nd_next = ov_r && mark_q;
        state_next = naf_pkg::S_IDLE;
      end
      default: begin
        state_next = naf_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    hit_we = 1'b0;
    hit_wa = rd_idx;
    hit_wd = 1'b0;
    cnt_we = 1'b0;
    cnt_wd = '0;
    mark_we = 1'b0;
    mark_wd = 1'b0;
    marked_total_next = marked_total;
    if (q_pop && (q_func == naf_pkg::F_RECORD) && q_ov) begin
      hit_we = 1'b1;
      hit_wa = q_off;
      hit_wd = 1'b1;
    end
    if (rd_valid) begin
      if (init_w || (op == naf_pkg::F_START_RUN)) hit_we = 1'b1;
      if (init_w || (op == naf_pkg::F_START_DET)) cnt_we = 1'b1;
      if (!init_w && (op == naf_pkg::F_END_RUN) && hit_q) begin
        cnt_we = 1'b1;
        cnt_wd = cnt_q + 1'b1;
      end
      if (init_w) mark_we = 1'b1;
      if (!init_w && (op == naf_pkg::F_END_DET) && (cnt_q != '0) &&
          (cnt_q != run_count) && !mark_q) begin
        mark_we = 1'b1;
        mark_wd = 1'b1;
        marked_total_next = marked_total + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= naf_pkg::S_INIT;
      cnt <= '0;
      rd_valid <= 1'b0;
      run_count <= '0;
      marked_total <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      rd_valid <= rd_valid_next;
      run_count <= run_count_next;
      marked_total <= marked_total_next;
      if (load_rsp) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= rd_idx_next;
    op <= op_next;
    ov_r <= ov_r_next;
    if (load_rsp) begin
      rsp_nd <= nd_next;
      rsp_count <= marked_total;
    end
  end

  always_ff @(posedge clk) begin
    hit_q <= hit_mem[raddr];
    if (hit_we) hit_mem[hit_wa] <= hit_wd;
  end

  always_ff @(posedge clk) begin
    cnt_q <= cnt_mem[raddr];
    if (cnt_we) cnt_mem[rd_idx] <= cnt_wd;
  end

  always_ff @(posedge clk) begin
    mark_q <= mark_mem[raddr];
    if (mark_we) mark_mem[rd_idx] <= mark_wd;
  end
endmodule

@@ rtl/naf_checker.sv @@
// Port-level checks for the filter top level, with its bind.
`timescale 1ns / 1ps
module naf_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [naf_pkg::TOTAL_W-1:0]  new_count,
  input logic                         pready
);
  a_init_blocks_req: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("req ready during clearing pass");
  a_no_rsp_after_rst: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result right after reset");
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(new_count))
    else $error("stalled result changed");
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");
endmodule

bind nondeterministic_address_filter_top naf_checker u_naf_checker (
  .clk(clk),
  .rst(rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .new_count(rsp.new_count),
  .pready(pready)
);
